### design/trd_pkg.sv
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and codes for the telemetry record deserializer.
// ----------------------------------------------------------------------------
package trd_pkg;

   localparam int unsigned KindW      = 4;
   localparam int unsigned ValueW     = 64;
   localparam int unsigned StatusW    = 3;
   localparam int unsigned PhaseW     = 4;
   localparam int unsigned LeftW      = 16;
   localparam int unsigned AgentLimW  = 9;
   localparam int unsigned PayLimW    = 16;
   localparam int unsigned AddrLimW   = 9;
   localparam int unsigned CsrAddrW   = 2;
   localparam int unsigned CsrDataW   = 16;
   localparam int unsigned ReqDataW   = 8;
   localparam int unsigned RspDataW   = 72;

   // parse phases
   localparam logic [PhaseW-1:0] PH_TS        = 4'd0;
   localparam logic [PhaseW-1:0] PH_IFX       = 4'd1;
   localparam logic [PhaseW-1:0] PH_QUEUE     = 4'd2;
   localparam logic [PhaseW-1:0] PH_ACTION    = 4'd3;
   localparam logic [PhaseW-1:0] PH_LABEL     = 4'd4;
   localparam logic [PhaseW-1:0] PH_DATALEN   = 4'd5;
   localparam logic [PhaseW-1:0] PH_AGENT_LEN = 4'd6;
   localparam logic [PhaseW-1:0] PH_AGENT     = 4'd7;
   localparam logic [PhaseW-1:0] PH_PAY_LEN   = 4'd8;
   localparam logic [PhaseW-1:0] PH_PAYLOAD   = 4'd9;
   localparam logic [PhaseW-1:0] PH_SRC_LEN   = 4'd10;
   localparam logic [PhaseW-1:0] PH_SRC       = 4'd11;
   localparam logic [PhaseW-1:0] PH_DST_LEN   = 4'd12;
   localparam logic [PhaseW-1:0] PH_DST       = 4'd13;
   localparam logic [PhaseW-1:0] PH_SPORT     = 4'd14;
   localparam logic [PhaseW-1:0] PH_DPORT     = 4'd15;

   // result kinds
   localparam logic [KindW-1:0] KIND_AGENT   = 4'd6;
   localparam logic [KindW-1:0] KIND_PAYLOAD = 4'd7;
   localparam logic [KindW-1:0] KIND_SRCIP   = 4'd8;
   localparam logic [KindW-1:0] KIND_DSTIP   = 4'd9;
   localparam logic [KindW-1:0] KIND_SPORT   = 4'd10;
   localparam logic [KindW-1:0] KIND_DPORT   = 4'd11;
   localparam logic [KindW-1:0] KIND_END     = 4'd12;

   // status codes
   localparam logic [StatusW-1:0] STAT_OK        = 3'd0;
   localparam logic [StatusW-1:0] STAT_TRUNC     = 3'd1;
   localparam logic [StatusW-1:0] STAT_AGENT_LEN = 3'd2;
   localparam logic [StatusW-1:0] STAT_PAY_LEN   = 3'd3;
   localparam logic [StatusW-1:0] STAT_SRC_LEN   = 3'd4;
   localparam logic [StatusW-1:0] STAT_DST_LEN   = 3'd5;

   // register indexes
   localparam logic [CsrAddrW-1:0] CSR_AGENT_LIMIT   = 2'd0;
   localparam logic [CsrAddrW-1:0] CSR_PAYLOAD_LIMIT = 2'd1;
   localparam logic [CsrAddrW-1:0] CSR_ADDR_LIMIT    = 2'd2;

   localparam logic [AgentLimW-1:0] AGENT_LIMIT_RST   = 9'd64;
   localparam logic [PayLimW-1:0]   PAYLOAD_LIMIT_RST = 16'd256;
   localparam logic [AddrLimW-1:0]  ADDR_LIMIT_RST    = 9'd64;

   typedef struct packed {
      logic [KindW-1:0]   kind;
      logic [ValueW-1:0]  value;
      logic [StatusW-1:0] status;
      logic               last;
   } trd_item_type;

   typedef struct packed {
      logic [1:0]   count;
      trd_item_type first;
      trd_item_type second;
   } trd_result_type;

   typedef struct packed {
      logic [AgentLimW-1:0] agent;
      logic [PayLimW-1:0]   payload;
      logic [AddrLimW-1:0]  addr;
   } trd_limits_type;

endpackage

### design/telemetry_record_deserializer.sv
// ----------------------------------------------------------------------------
// telemetry_record_deserializer
// Little-endian telemetry record parser, one byte per item in, field items out.
// ----------------------------------------------------------------------------
// Each result item is registered in the result queue as its byte is accepted.
// Throughput: one byte per cycle unless req_tready is low; one pass per byte.
// A closing byte may give two result items; a four-entry result queue takes
// them, and req_tready drops only while three or more items wait.
// Reset clears the parse state and queue and sets the limits to 64, 256, 64.
module telemetry_record_deserializer (
   input  logic                           clock,
   input  logic                           reset,
   // request: tdata = data_byte[7:0]; tlast = final_byte
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [trd_pkg::ReqDataW-1:0]   req_tdata,
   input  logic                           req_tlast,
   // result: tdata = field_value[63:0], status[66:64], zero pad[71:67]
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [trd_pkg::RspDataW-1:0]   rsp_tdata,
   // result: tuser = field_kind[3:0]; tlast = record_end
   output logic [trd_pkg::KindW-1:0]      rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_we,
   input  logic [trd_pkg::CsrAddrW-1:0]   csr_addr,
   input  logic [trd_pkg::CsrDataW-1:0]   csr_wdata
);
   import trd_pkg::*;

   trd_limits_type limits_ff, limits_in;
   trd_result_type result;
   trd_item_type   queue_ff [4];
   trd_item_type   head;
   logic [1:0]     wr_ptr_ff, wr_ptr_in;
   logic [1:0]     rd_ptr_ff, rd_ptr_in;
   logic [2:0]     count_ff, count_in;
   logic           accept;
   logic           pop;

   always_comb begin
      limits_in = limits_ff;
      if (csr_we) begin
         unique case (csr_addr)
            CSR_AGENT_LIMIT:   limits_in.agent   = csr_wdata[AgentLimW-1:0];
            CSR_PAYLOAD_LIMIT: limits_in.payload = csr_wdata[PayLimW-1:0];
            CSR_ADDR_LIMIT:    limits_in.addr    = csr_wdata[AddrLimW-1:0];
            default:           limits_in         = limits_ff;
         endcase
      end
   end

   assign req_tready = (count_ff < 3'd3);
   assign accept     = req_tvalid && req_tready;

   trd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_tdata),
      .final_byte (req_tlast),
      .limits     (limits_ff),
      .result     (result)
   );

   assign head       = queue_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 3'd0);
   assign rsp_tdata  = {5'd0, head.status, head.value};
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;
   assign pop        = rsp_tvalid && rsp_tready;

   assign wr_ptr_in = wr_ptr_ff + result.count;
   assign rd_ptr_in = rd_ptr_ff + {1'b0, pop};
   assign count_in  = count_ff + {1'b0, result.count} - {2'd0, pop};

   always_ff @(posedge clock) begin
      if (result.count != 2'd0) begin
         queue_ff[wr_ptr_ff] <= result.first;
      end
      if (result.count == 2'd2) begin
         queue_ff[wr_ptr_ff + 2'd1] <= result.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limits_ff <= '{agent: AGENT_LIMIT_RST, payload: PAYLOAD_LIMIT_RST,
                        addr: ADDR_LIMIT_RST};
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         limits_ff <= limits_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/trd_parser.sv
// ----------------------------------------------------------------------------
// trd_parser
// Byte-wise record parser: phase, byte count and assembly register, plus the
// zero, one or two result items caused by each accepted byte.
// ----------------------------------------------------------------------------
module trd_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             data_byte,
   input  logic                   final_byte,
   input  trd_pkg::trd_limits_type limits,
   output trd_pkg::trd_result_type result
);
   import trd_pkg::*;

   logic [PhaseW-1:0] phase_ff, phase_in;
   logic [LeftW-1:0]  left_ff, left_in;
   logic [ValueW-1:0] asm_ff, asm_in;
   logic              skip_ff, skip_in;

   logic [LeftW-1:0]     left_dec;
   logic [ValueW-1:0]    asm_shift;
   logic [ValueW-1:0]    field_value;
   logic [AgentLimW-1:0] len_limit;
   logic [StatusW-1:0]   err;
   logic                 done;
   logic [KindW-1:0]     str_kind;
   logic [StatusW-1:0]   len_code;

   // byte count loaded on entry to a phase
   function automatic logic [LeftW-1:0] entry_left(input logic [PhaseW-1:0] ph);
      logic [LeftW-1:0] n;
      begin
         n = 16'd1;
         if (ph == PH_PAY_LEN) begin
            n = 16'd2;
         end else if (ph == PH_SPORT || ph == PH_DPORT) begin
            n = 16'd4;
         end
         return n;
      end
   endfunction

   always_comb begin
      phase_in  = phase_ff;
      left_in   = left_ff;
      asm_in    = asm_ff;
      skip_in   = skip_ff;
      result    = '0;
      err       = STAT_OK;
      done      = 1'b0;
      left_dec  = left_ff - 16'd1;
      asm_shift = {data_byte, asm_ff[ValueW-1:8]};
      len_limit = (phase_ff == PH_AGENT_LEN) ? limits.agent : limits.addr;

      unique case (phase_ff) inside
         PH_TS:      field_value = asm_shift;
         PH_PAY_LEN: field_value = {48'd0, asm_shift[63:48]};
         default:    field_value = {32'd0, asm_shift[63:32]};
      endcase

      unique case (phase_ff) inside
         PH_AGENT:   str_kind = KIND_AGENT;
         PH_PAYLOAD: str_kind = KIND_PAYLOAD;
         PH_SRC:     str_kind = KIND_SRCIP;
         default:    str_kind = KIND_DSTIP;
      endcase

      unique case (phase_ff) inside
         PH_AGENT_LEN: len_code = STAT_AGENT_LEN;
         PH_SRC_LEN:   len_code = STAT_SRC_LEN;
         default:      len_code = STAT_DST_LEN;
      endcase

      if (accept) begin
         if (skip_ff) begin
            if (final_byte) begin
               phase_in = PH_TS;
               left_in  = 16'd8;
               asm_in   = '0;
               skip_in  = 1'b0;
            end
         end else begin
            unique case (phase_ff) inside
               PH_TS, PH_IFX, PH_QUEUE, PH_ACTION, PH_LABEL, PH_DATALEN,
               PH_PAY_LEN, PH_SPORT, PH_DPORT: begin
                  asm_in  = asm_shift;
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     if (phase_ff == PH_PAY_LEN) begin
                        if (field_value[15:0] > limits.payload) begin
                           err = STAT_PAY_LEN;
                        end else if (field_value[15:0] == 16'd0) begin
                           phase_in = PH_SRC_LEN;
                           left_in  = 16'd1;
                        end else begin
                           phase_in = PH_PAYLOAD;
                           left_in  = field_value[15:0];
                        end
                     end else if (phase_ff == PH_DPORT) begin
                        result.count = 2'd1;
                        result.first = '{kind: KIND_DPORT, value: field_value,
                                         status: STAT_OK, last: 1'b0};
                        done = 1'b1;
                     end else if (phase_ff == PH_SPORT) begin
                        result.count = 2'd1;
                        result.first = '{kind: KIND_SPORT, value: field_value,
                                         status: STAT_OK, last: 1'b0};
                        phase_in = PH_DPORT;
                        left_in  = 16'd4;
                     end else begin
                        // fixed header words: kind code matches the phase
                        result.count = 2'd1;
                        result.first = '{kind: phase_ff, value: field_value,
                                         status: STAT_OK, last: 1'b0};
                        phase_in = phase_ff + 4'd1;
                        left_in  = (phase_ff == PH_DATALEN) ? 16'd1 : 16'd4;
                     end
                  end
               end
               PH_AGENT_LEN, PH_SRC_LEN, PH_DST_LEN: begin
                  if ({1'b0, data_byte} >= len_limit) begin
                     err = len_code;
                  end else if (data_byte != 8'd0) begin
                     phase_in = phase_ff + 4'd1;
                     left_in  = {8'd0, data_byte};
                  end else begin
                     // empty string: skip its byte phase
                     phase_in = phase_ff + 4'd2;
                     left_in  = entry_left(phase_ff + 4'd2);
                  end
               end
               default: begin
                  result.count = 2'd1;
                  result.first = '{kind: str_kind, value: {56'd0, data_byte},
                                   status: STAT_OK, last: 1'b0};
                  left_in = left_dec;
                  if (left_dec == '0) begin
                     phase_in = phase_ff + 4'd1;
                     left_in  = entry_left(phase_ff + 4'd1);
                  end
               end
            endcase

            if (err != STAT_OK || done || final_byte) begin
               if (result.count == 2'd0) begin
                  result.first = '{kind: KIND_END, value: '0,
                                   status: (err != STAT_OK) ? err :
                                           (done ? STAT_OK : STAT_TRUNC),
                                   last: 1'b1};
                  result.count = 2'd1;
               end else begin
                  result.second = '{kind: KIND_END, value: '0,
                                    status: (err != STAT_OK) ? err :
                                            (done ? STAT_OK : STAT_TRUNC),
                                    last: 1'b1};
                  result.count  = 2'd2;
               end
               if (final_byte) begin
                  phase_in = PH_TS;
                  left_in  = 16'd8;
                  asm_in   = '0;
                  skip_in  = 1'b0;
               end else begin
                  skip_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_TS;
         left_ff  <= 16'd8;
         asm_ff   <= '0;
         skip_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
         asm_ff   <= asm_in;
         skip_ff  <= skip_in;
      end
   end

endmodule

### design/trd_checker.sv
// ----------------------------------------------------------------------------
// trd_checker
// Port-level checks for the telemetry record deserializer, bound to the top.
// ----------------------------------------------------------------------------
module trd_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [trd_pkg::RspDataW-1:0] rsp_tdata,
   input logic [trd_pkg::KindW-1:0]    rsp_tuser,
   input logic                         rsp_tlast
);
   import trd_pkg::*;

   // a waiting result item holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                    $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled result item changed");

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid straight after reset");

   // record end and end kind go together
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tuser == KIND_END)))
      else $error("record end flag and kind disagree");

   // status only on the closing item
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[66:64] == STAT_OK)
      else $error("status on a field item");

   // an empty result side never holds back bytes
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with nothing queued");

endmodule

bind telemetry_record_deserializer trd_checker u_trd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
